@@ hw/rtl/stbs_pkg.sv @@
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int INDEX_W     = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = 11;
  localparam int BOUND_W     = INDEX_W + 1;
  localparam int DATA_W      = 32;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [INDEX_W-1:0]       entry_index;
    logic signed [DATA_W-1:0] data_value;
  } request_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } result_t;

  typedef struct packed {
    logic load;
    logic read;
    logic step;
    logic finish_found;
    logic finish_miss;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
  } dp_status_t;

endpackage

@@ hw/rtl/stbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// stbs_ctrl
// Search sequencer: alternates a table read and a compare until a hit or an
// empty range.
// ----------------------------------------------------------------------------
module stbs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 mode,
  input  stbs_pkg::dp_status_t status,
  output stbs_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);
  import stbs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_CMP  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start && mode == MODE_SEARCH) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (status.empty) begin
          cmd.finish_miss = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.read   = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (status.hit) begin
          cmd.finish_found = 1'b1;
          state_next       = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ hw/rtl/stbs_dp.sv @@
// ----------------------------------------------------------------------------
// stbs_dp
// Table memory, entry count register, search bounds, key compare and result
// register.
// ----------------------------------------------------------------------------
module stbs_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_en,
  input  stbs_pkg::request_t            request,
  input  logic                          cfg_we,
  input  logic [stbs_pkg::COUNT_W-1:0]  cfg_data,
  input  stbs_pkg::ctrl_cmd_t           cmd,
  output stbs_pkg::dp_status_t          status,
  output logic                          done,
  output stbs_pkg::result_t             result
);
  import stbs_pkg::*;

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] word;
  logic signed [DATA_W-1:0] key;
  logic [COUNT_W-1:0]       entry_count;
  logic [BOUND_W-1:0]       low;
  logic [BOUND_W-1:0]       high_x;
  logic [BOUND_W-1:0]       count_sat;
  logic [BOUND_W:0]         mid_sum;
  logic [INDEX_W-1:0]       mid;

  always_ff @(posedge clk) begin
    if (write_en && ({1'b0, request.entry_index} < BOUND_W'(TABLE_DEPTH))) begin
      mem[request.entry_index] <= request.data_value;
    end
    if (cmd.read) begin
      word <= mem[mid];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_data;
    end
  end

  assign count_sat = (entry_count > COUNT_W'(TABLE_DEPTH)) ? BOUND_W'(TABLE_DEPTH)
                                                           : BOUND_W'(entry_count);
  assign mid_sum   = {1'b0, low} + {1'b0, high_x} - (BOUND_W+1)'(1);
  assign mid       = mid_sum[INDEX_W:1];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key    <= request.data_value;
      low    <= '0;
      high_x <= count_sat;
    end else if (cmd.step) begin
      if (key > word) begin
        low <= {1'b0, mid} + BOUND_W'(1);
      end else begin
        high_x <= {1'b0, mid};
      end
    end
  end

  assign status.empty = (low >= high_x);
  assign status.hit   = (word == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish_found || cmd.finish_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_found) begin
      result.found    <= 1'b1;
      result.position <= mid;
    end else if (cmd.finish_miss) begin
      result.found    <= 1'b0;
      result.position <= '0;
    end
  end

endmodule

@@ hw/rtl/sorted_table_binary_search.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// A request with mode write stores data_value at entry_index and gives no
// result; busy stays low. A request with mode search runs a binary search over
// the first entry_count entries (count saturates at the table depth). Each
// probe is a registered table read followed by a compare; the search ends on
// a match or when the search range is empty. The result shows on result for
// one cycle with done high, the first cycle with busy low again; the receiver
// cannot stall it. The table has no reset and must be written before it is
// searched. The user must write entry_count through cfg_valid/cfg_data only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sorted_table_binary_search (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  stbs_pkg::request_t           request,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [stbs_pkg::COUNT_W-1:0] cfg_data,
  output logic                         done,
  output stbs_pkg::result_t            result
);
  import stbs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       write_en;

  assign cfg_ready = 1'b1;
  assign write_en  = start && !busy && (request.mode == MODE_WRITE);

  stbs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (request.mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  stbs_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .write_en (write_en),
    .request  (request),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .done     (done),
    .result   (result)
  );

endmodule
